// File: hdl/hmd_pkg.sv
package hmd_pkg;

  localparam int STORE_BYTES = 65536;
  localparam int BANK_BYTES  = 1024;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int BANK_W      = ADDR_W - $clog2(BANK_BYTES);
  localparam int OFFS_W      = $clog2(BANK_BYTES);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPANSION = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CARTRIDGE = CFG_IDX_W'(1);

  // Colour RAM occupies one bank at 0x9400.
  localparam logic [BANK_W-1:0] COLOUR_BANK  = BANK_W'(37);
  localparam logic [7:0]        COLOUR_RESET = 8'h03;

  typedef enum logic [2:0] {
    OP_CPU_READ    = 3'd0,
    OP_CPU_WRITE   = 3'd1,
    OP_VIDEO_READ  = 3'd2,
    OP_COLOUR_READ = 3'd3,
    OP_LOAD_WRITE  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    IO_NONE  = 2'd0,
    IO_VIDEO = 2'd1,
    IO_VIA1  = 2'd2,
    IO_VIA2  = 2'd3
  } io_target_t;

  typedef enum logic [2:0] {
    RD_PASS       = 3'd0,
    RD_MEM        = 3'd1,
    RD_COLOUR_CPU = 3'd2,
    RD_COLOUR_LOW = 3'd3,
    RD_FLOAT_HIGH = 3'd4
  } rd_mode_t;

  typedef struct packed {
    logic              mem_wr;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    rd_mode_t          rd_mode;
    logic [7:0]        data_in;
    io_target_t        io_target;
    logic [3:0]        io_register;
    logic              io_is_write;
    logic [7:0]        io_data;
  } cmd_t;

endpackage

// File: hdl/hmd_ram.sv
module hmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hdl/hmd_front.sv
module hmd_front
  import hmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [2:0]            in_operation,
  input  logic [15:0]           in_address,
  input  logic [7:0]            in_data_in,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  push,
  output cmd_t                  cmd
);

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_IO,
    KIND_ROM,
    KIND_RAM
  } kind_t;

  logic [3:0]        expansion_r;
  logic              cartridge_r;
  logic [BANK_W-1:0] bank;
  logic [1:0]        page;
  logic [ADDR_W-1:0] colour_addr;
  logic [13:0]       video_addr;
  kind_t             kind;
  io_target_t        chip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expansion_r <= '0;
      cartridge_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXPANSION: expansion_r <= cfg_data[3:0];
        CFG_CARTRIDGE: cartridge_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign push        = start && !busy;
  assign bank        = in_address[ADDR_W-1 -: BANK_W];
  assign page        = bank[1:0];
  assign colour_addr = {COLOUR_BANK, in_address[OFFS_W-1:0]};
  assign video_addr  = in_address[13:0];

  always_comb begin
    if (bank == BANK_W'(0) || (bank >= BANK_W'(4) && bank <= BANK_W'(7))) begin
      kind = KIND_RAM;
    end else if (bank <= BANK_W'(3)) begin
      kind = expansion_r[0] ? KIND_RAM : KIND_NONE;
    end else if (bank <= BANK_W'(15)) begin
      kind = expansion_r[1] ? KIND_RAM : KIND_NONE;
    end else if (bank <= BANK_W'(23)) begin
      kind = expansion_r[2] ? KIND_RAM : KIND_NONE;
    end else if (bank <= BANK_W'(31)) begin
      kind = expansion_r[3] ? KIND_RAM : KIND_NONE;
    end else if (bank <= BANK_W'(35)) begin
      kind = KIND_ROM;
    end else if (bank <= BANK_W'(39)) begin
      kind = KIND_IO;
    end else if (bank <= BANK_W'(47)) begin
      kind = cartridge_r ? KIND_ROM : KIND_NONE;
    end else begin
      kind = KIND_ROM;
    end
  end

  // Register windows repeat every 64 bytes; the top 16 fold back to the video chip.
  always_comb begin
    case (in_address[5:4])
      2'd0:    chip = IO_VIDEO;
      2'd1:    chip = IO_VIA1;
      2'd2:    chip = IO_VIA2;
      default: chip = IO_VIDEO;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.mem_addr    = in_address;
    cmd.mem_wdata   = in_data_in;
    cmd.rd_mode     = RD_PASS;
    cmd.data_in     = in_data_in;
    cmd.io_target   = IO_NONE;
    case (op_t'(in_operation))
      OP_CPU_READ: begin
        if (kind == KIND_RAM || kind == KIND_ROM) begin
          cmd.rd_mode = RD_MEM;
        end else if (kind == KIND_IO) begin
          if (page == 2'd0) begin
            cmd.io_target   = chip;
            cmd.io_register = in_address[3:0];
          end else if (page == 2'd1) begin
            cmd.mem_addr = colour_addr;
            cmd.rd_mode  = RD_COLOUR_CPU;
          end else begin
            cmd.rd_mode = RD_FLOAT_HIGH;
          end
        end
      end
      OP_CPU_WRITE: begin
        if (kind == KIND_RAM) begin
          cmd.mem_wr = 1'b1;
        end else if (kind == KIND_IO) begin
          if (page == 2'd0) begin
            cmd.io_target   = chip;
            cmd.io_register = in_address[3:0];
            cmd.io_is_write = 1'b1;
            cmd.io_data     = in_data_in;
          end else if (page == 2'd1) begin
            cmd.mem_wr    = 1'b1;
            cmd.mem_addr  = colour_addr;
            cmd.mem_wdata = {4'h0, in_data_in[3:0]};
          end
        end
      end
      OP_VIDEO_READ: begin
        if (!video_addr[13]) begin
          // Character ROM, mirrored every 4 KB.
          cmd.mem_addr = {4'h8, video_addr[11:0]};
          cmd.rd_mode  = RD_MEM;
        end else if (video_addr[12:10] != 3'd0 && video_addr[12:10] <= 3'd3 &&
                     !expansion_r[0]) begin
          cmd.rd_mode = RD_FLOAT_HIGH;
        end else begin
          cmd.mem_addr = {3'b000, video_addr[12:0]};
          cmd.rd_mode  = RD_MEM;
        end
      end
      OP_COLOUR_READ: begin
        cmd.mem_addr = colour_addr;
        cmd.rd_mode  = RD_COLOUR_LOW;
      end
      OP_LOAD_WRITE: begin
        cmd.mem_wr = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/hmd_queue.sv
module hmd_queue
  import hmd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic empty,
  output logic full
);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hdl/hmd_back.sv
module hmd_back
  import hmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_t       q_cmd,
  output logic       pop,
  output logic       clearing,
  output logic       out_strobe,
  output logic [7:0] out_read_data,
  output logic [1:0] out_io_target,
  output logic [3:0] out_io_register,
  output logic       out_io_is_write,
  output logic [7:0] out_io_data
);

  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              pend_valid_r;
  rd_mode_t          pend_rd_mode_r;
  logic [7:0]        pend_data_in_r;
  io_target_t        pend_io_target_r;
  logic [3:0]        pend_io_register_r;
  logic              pend_io_is_write_r;
  logic [7:0]        pend_io_data_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic [7:0]        clr_value;

  assign clearing  = clearing_r;
  assign pop       = !q_empty && !clearing_r;
  assign clr_value = (clr_addr_r[ADDR_W-1 -: BANK_W] == COLOUR_BANK) ? COLOUR_RESET : 8'h00;

  // Each item either reads or writes the store, so one port serves both.
  assign ram_we    = clearing_r || (pop && q_cmd.mem_wr);
  assign ram_addr  = clearing_r ? clr_addr_r : q_cmd.mem_addr;
  assign ram_wdata = clearing_r ? clr_value : q_cmd.mem_wdata;

  hmd_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r   <= 1'b1;
      clr_addr_r   <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          clearing_r <= 1'b0;
        end
      end
      pend_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pend_rd_mode_r     <= q_cmd.rd_mode;
      pend_data_in_r     <= q_cmd.data_in;
      pend_io_target_r   <= q_cmd.io_target;
      pend_io_register_r <= q_cmd.io_register;
      pend_io_is_write_r <= q_cmd.io_is_write;
      pend_io_data_r     <= q_cmd.io_data;
    end
  end

  always_comb begin
    case (pend_rd_mode_r)
      RD_PASS:       out_read_data = pend_data_in_r;
      RD_MEM:        out_read_data = ram_rdata;
      RD_COLOUR_CPU: out_read_data = ram_rdata | 8'hF0;
      RD_COLOUR_LOW: out_read_data = ram_rdata & 8'h0F;
      RD_FLOAT_HIGH: out_read_data = 8'hFF;
      default:       out_read_data = pend_data_in_r;
    endcase
  end

  assign out_strobe      = pend_valid_r;
  assign out_io_target   = pend_io_target_r;
  assign out_io_register = pend_io_register_r;
  assign out_io_is_write = pend_io_is_write_r;
  assign out_io_data     = pend_io_data_r;

endmodule

// File: hdl/home_computer_memory_decoder_top.sv
// Each accepted item is queued, then held in the pend registers, then strobed out.
// Throughput: one item per cycle while busy is low; each item takes a single access on the one store port.
// Reset: synchronous, active low. Afterwards busy stays high while all 65536 store
// bytes are swept to zero, colour RAM to 3; configuration writes are taken meanwhile.
// The receiver cannot stall, so results leave at a fixed time after acceptance.
module home_computer_memory_decoder_top
  import hmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_operation,
  input  logic [15:0]           in_address,
  input  logic [7:0]            in_data_in,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_strobe,
  output logic [7:0]            out_read_data,
  output logic [1:0]            out_io_target,
  output logic [3:0]            out_io_register,
  output logic                  out_io_is_write,
  output logic [7:0]            out_io_data
);

  logic push;
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_empty;
  logic q_full;
  logic pop;
  logic clearing;

  assign busy = clearing || q_full;

  hmd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_address   (in_address),
    .in_data_in   (in_data_in),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .cmd          (front_cmd)
  );

  hmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  hmd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_cmd           (head_cmd),
    .pop             (pop),
    .clearing        (clearing),
    .out_strobe      (out_strobe),
    .out_read_data   (out_read_data),
    .out_io_target   (out_io_target),
    .out_io_register (out_io_register),
    .out_io_is_write (out_io_is_write),
    .out_io_data     (out_io_data)
  );

endmodule

// File: hdl/hmd_checker.sv
module hmd_checker
  import hmd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic [1:0] out_io_target,
  input logic [3:0] out_io_register,
  input logic       out_io_is_write,
  input logic [7:0] out_io_data
);

  // The store sweep keeps the block busy right after reset.
  a_busy_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> busy)
    else $error("busy low right after reset");

  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_strobe)
    else $error("accepted item produced no result");

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 2))
    else $error("result without an accepted item");

  a_no_target_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_io_target == IO_NONE) |->
      (out_io_register == 4'h0 && !out_io_is_write))
    else $error("register fields set without a target");

  a_io_data_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_io_is_write) |-> out_io_data == 8'h00)
    else $error("forwarded data without a register write");

endmodule

bind home_computer_memory_decoder_top hmd_checker u_hmd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_io_target   (out_io_target),
  .out_io_register (out_io_register),
  .out_io_is_write (out_io_is_write),
  .out_io_data     (out_io_data)
);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import hmd_pkg::*;

  localparam int WATCHDOG_LIMIT  = 200000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RESET_CYCLES    = 6;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 237;
  localparam int MAX_REPORTS     = 10;
  localparam int IDLE_PERCENT    = 35;
  localparam int BUSY_PHASE      = 4;

  localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;
  localparam logic [15:0] CHAR_BASE      = 16'h8000;
  localparam logic [15:0] COLOUR_BASE    = 16'h9400;
  localparam logic [1:0]  PAGE_CHIPS     = 2'd0;
  localparam logic [1:0]  PAGE_COLOUR    = 2'd1;

  localparam logic [3:0] EXP_PLAN  [PHASES] = '{4'h0, 4'hF, 4'h5, 4'hA, 4'hF, 4'h0};
  localparam logic [3:0] CART_PLAN [PHASES] = '{4'h0, 4'h1, 4'hE, 4'h3, 4'h0, 4'h0};

  typedef enum logic [1:0] {AREA_NONE, AREA_IO, AREA_ROM, AREA_RAM} area_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
  } access_t;

  typedef struct packed {
    logic [7:0] read_data;
    io_target_t io_target;
    logic [3:0] io_register;
    logic       io_is_write;
    logic [7:0] io_data;
  } bus_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [2:0]            in_operation = '0;
  logic [15:0]           in_address = '0;
  logic [7:0]            in_data_in = '0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  out_strobe;
  logic [7:0]            out_read_data;
  logic [1:0]            out_io_target;
  logic [3:0]            out_io_register;
  logic                  out_io_is_write;
  logic [7:0]            out_io_data;

  // Mirror of the decoder's store and registers.
  logic [7:0] mem_image [0:STORE_BYTES-1];
  logic [3:0] exp_enable = '0;
  logic       cart_on = 1'b0;

  access_t     access_queue[$];
  bus_result_t expected_results[$];
  int idle_pct = IDLE_PERCENT;
  int accesses_done = 0;
  int results_checked = 0;
  int settings_used = 0;
  int errors = 0;
  int stall_cycles = 0;

  home_computer_memory_decoder_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_address     (in_address),
    .in_data_in     (in_data_in),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_strobe     (out_strobe),
    .out_read_data  (out_read_data),
    .out_io_target  (out_io_target),
    .out_io_register(out_io_register),
    .out_io_is_write(out_io_is_write),
    .out_io_data    (out_io_data)
  );

  always #5 clk = ~clk;

  function automatic area_t area_of(logic [5:0] bank);
    if (bank == 0 || (bank >= 4 && bank <= 7)) return AREA_RAM;
    if (bank <= 3) return exp_enable[0] ? AREA_RAM : AREA_NONE;
    if (bank <= 15) return exp_enable[1] ? AREA_RAM : AREA_NONE;
    if (bank <= 23) return exp_enable[2] ? AREA_RAM : AREA_NONE;
    if (bank <= 31) return exp_enable[3] ? AREA_RAM : AREA_NONE;
    if (bank <= 35) return AREA_ROM;
    if (bank <= 39) return AREA_IO;
    if (bank <= 47) return cart_on ? AREA_ROM : AREA_NONE;
    return AREA_ROM;
  endfunction

  // Within each 64-byte window: video chip, first VIA, second VIA, video chip again.
  function automatic io_target_t chip_of(logic [5:0] offset);
    case (offset[5:4])
      2'd1:    return IO_VIA1;
      2'd2:    return IO_VIA2;
      default: return IO_VIDEO;
    endcase
  endfunction

  // Works out the result of one access and applies its side effect to the mirror.
  function automatic bus_result_t decode_access(access_t a);
    bus_result_t r;
    area_t       area;
    logic [15:0] colour_addr;
    logic [13:0] vaddr;
    r.read_data   = a.data;
    r.io_target   = IO_NONE;
    r.io_register = 4'd0;
    r.io_is_write = 1'b0;
    r.io_data     = 8'd0;
    area        = area_of(a.addr[15:10]);
    colour_addr = COLOUR_BASE | {6'd0, a.addr[9:0]};
    vaddr       = a.addr[13:0];
    case (a.op)
      OP_CPU_READ: begin
        if (area == AREA_RAM || area == AREA_ROM) begin
          r.read_data = mem_image[a.addr];
        end else if (area == AREA_IO) begin
          if (a.addr[11:10] == PAGE_CHIPS) begin
            r.io_target   = chip_of(a.addr[5:0]);
            r.io_register = a.addr[3:0];
          end else if (a.addr[11:10] == PAGE_COLOUR) begin
            r.read_data = mem_image[colour_addr] | 8'hF0;
          end else begin
            r.read_data = 8'hFF;
          end
        end
      end
      OP_CPU_WRITE: begin
        if (area == AREA_RAM) begin
          mem_image[a.addr] = a.data;
        end else if (area == AREA_IO) begin
          if (a.addr[11:10] == PAGE_CHIPS) begin
            r.io_target   = chip_of(a.addr[5:0]);
            r.io_register = a.addr[3:0];
            r.io_is_write = 1'b1;
            r.io_data     = a.data;
          end else if (a.addr[11:10] == PAGE_COLOUR) begin
            mem_image[colour_addr] = a.data & 8'h0F;
          end
        end
      end
      OP_VIDEO_READ: begin
        if (vaddr < 14'h2000) begin
          r.read_data = mem_image[CHAR_BASE | {4'd0, vaddr[11:0]}];
        end else if (vaddr >= 14'h2400 && vaddr < 14'h3000 && !exp_enable[0]) begin
          r.read_data = 8'hFF;
        end else begin
          r.read_data = mem_image[{3'd0, vaddr[12:0]}];
        end
      end
      OP_COLOUR_READ: r.read_data = mem_image[colour_addr] & 8'h0F;
      OP_LOAD_WRITE:  mem_image[a.addr] = a.data;
      default: ;
    endcase
    return r;
  endfunction

  function automatic access_t random_access();
    access_t a;
    int      pick;
    pick = $urandom_range(99);
    if (pick < 28)      a.op = OP_CPU_READ;
    else if (pick < 52) a.op = OP_CPU_WRITE;
    else if (pick < 64) a.op = OP_VIDEO_READ;
    else if (pick < 74) a.op = OP_COLOUR_READ;
    else if (pick < 94) a.op = OP_LOAD_WRITE;
    else                a.op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    // Half of the addresses crowd onto a few bytes per bank so reads find earlier writes.
    if ($urandom_range(1) == 0) a.addr = {6'($urandom_range(63)), 6'd0, 4'($urandom_range(15))};
    else                        a.addr = 16'($urandom);
    a.data = 8'($urandom);
    return a;
  endfunction

  task automatic add(logic [2:0] op, logic [15:0] addr, logic [7:0] data);
    access_t a;
    a.op   = op;
    a.addr = addr;
    a.data = data;
    access_queue.push_back(a);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_EXPANSION) exp_enable = val[3:0];
    else                      cart_on = val[0];
  endtask

  // Waits until every queued item is taken and its result has come back.
  task automatic drain();
    while (access_queue.size() > 0 || start || expected_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive
    access_t cur;
    access_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        cur.op   = in_operation;
        cur.addr = in_address;
        cur.data = in_data_in;
        expected_results.push_back(decode_access(cur));
        accesses_done++;
      end
      if (!(start && busy)) begin
        if (access_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = access_queue.pop_front();
          start        <= 1'b1;
          in_operation <= nxt.op;
          in_address   <= nxt.addr;
          in_data_in   <= nxt.data;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check
    bus_result_t want;
    bus_result_t got;
    if (rst_n && out_strobe) begin
      got.read_data   = out_read_data;
      got.io_target   = io_target_t'(out_io_target);
      got.io_register = out_io_register;
      got.io_is_write = out_io_is_write;
      got.io_data     = out_io_data;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no item outstanding: rd=%02h tgt=%0d reg=%0d wr=%0b iod=%02h",
                   $time, got.read_data, got.io_target, got.io_register, got.io_is_write,
                   got.io_data);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.read_data !== want.read_data || got.io_target !== want.io_target ||
            got.io_register !== want.io_register || got.io_is_write !== want.io_is_write ||
            got.io_data !== want.io_data) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: mismatch: expected rd=%02h tgt=%0d reg=%0d wr=%0b iod=%02h, got rd=%02h tgt=%0d reg=%0d wr=%0b iod=%02h",
                     $time, want.read_data, want.io_target, want.io_register, want.io_is_write,
                     want.io_data, got.read_data, got.io_target, got.io_register,
                     got.io_is_write, got.io_data);
        end
      end
    end
  end

  // The store clear after reset keeps busy high for a long while, hence the generous limit.
  always @(posedge clk) begin : watchdog
    if ((start && !busy) || out_strobe) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Timed out after %0d cycles without progress.", stall_cycles);
      $display("FAIL home_computer_memory_decoder_top");
      $finish;
    end
  end

  initial begin : stimulus
    for (int i = 0; i < STORE_BYTES; i++)
      mem_image[i] = (i >= COLOUR_BASE && i < COLOUR_BASE + BANK_BYTES) ? COLOUR_RESET : 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(CFG_EXPANSION, 4'h0);
    write_reg(CFG_CARTRIDGE, 4'h0);

    // Directed items with no expansion RAM and no cartridge.
    add(OP_CPU_WRITE, 16'h03FF, 8'hFF);
    add(OP_CPU_READ, 16'h03FF, 8'h00);
    add(OP_CPU_READ, 16'h0000, 8'hA5);
    add(OP_CPU_WRITE, 16'h0400, 8'h77);   // unmapped, dropped
    add(OP_CPU_READ, 16'h0400, 8'h3C);    // floating bus returns the input byte
    add(OP_CPU_WRITE, 16'hC000, 8'h11);   // ROM is write protected
    add(OP_LOAD_WRITE, 16'hFFFF, 8'h5A);
    add(OP_CPU_READ, 16'hFFFF, 8'h00);
    add(OP_LOAD_WRITE, 16'h8000, 8'hC3);
    add(OP_VIDEO_READ, 16'h1000, 8'h00);  // character ROM mirror
    add(OP_VIDEO_READ, 16'hFFFF, 8'h00);
    add(OP_VIDEO_READ, 16'h2400, 8'h00);  // expansion hole reads all ones
    add(OP_VIDEO_READ, 16'h3FFF, 8'h00);
    add(OP_CPU_READ, 16'h9000, 8'h81);
    add(OP_CPU_WRITE, 16'h9010, 8'hFE);
    add(OP_CPU_WRITE, 16'h902F, 8'h01);
    add(OP_CPU_READ, 16'h93FF, 8'h42);
    add(OP_CPU_WRITE, 16'h9400, 8'hAB);   // colour RAM keeps the low nibble
    add(OP_CPU_READ, 16'h9400, 8'h00);
    add(OP_COLOUR_READ, 16'h0000, 8'h00);
    add(OP_COLOUR_READ, 16'hFFFF, 8'h00);
    add(OP_CPU_READ, 16'h9800, 8'h00);
    add(OP_CPU_WRITE, 16'h9FFF, 8'h99);
    add(OP_CPU_READ, 16'hA000, 8'h6D);
    add(OP_CPU_READ, 16'h8FFF, 8'h00);
    add(OP_SPARE_FIRST, 16'h1234, 8'hE7);
    add(OP_SPARE_LAST, 16'hFFFF, 8'hFF);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      if (phase == PHASES - 1) begin
        write_reg(CFG_EXPANSION, 4'($urandom));
        write_reg(CFG_CARTRIDGE, 4'($urandom));
      end else begin
        write_reg(CFG_EXPANSION, EXP_PLAN[phase]);
        write_reg(CFG_CARTRIDGE, CART_PLAN[phase]);
      end
      settings_used++;
      idle_pct = (phase == BUSY_PHASE) ? 0 : IDLE_PERCENT;
      repeat (ITEMS_PER_PHASE) access_queue.push_back(random_access());
    end
    drain();

    if (expected_results.size() != 0) errors += expected_results.size();
    $display("Ran %0d accesses over %0d register settings; %0d results checked, %0d errors.",
             accesses_done, settings_used, results_checked, errors);
    if (errors == 0) begin
      $display("PASS home_computer_memory_decoder_top");
    end else begin
      $display("FAIL home_computer_memory_decoder_top");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/hmd_pkg.sv
hdl/hmd_ram.sv
hdl/hmd_front.sv
hdl/hmd_queue.sv
hdl/hmd_back.sv
hdl/home_computer_memory_decoder_top.sv
hdl/hmd_checker.sv
tb/tb.sv
